@@ hdl/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared widths, register indexes and types of the silence run detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

  // default parameter values
  localparam int INDEX_BITS_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // register and field widths
  localparam int THR_W      = 16;
  localparam int MS_W       = 16;
  localparam int RATE_W     = 19;
  localparam int SRC_W      = 40;
  localparam int OUT_W      = 41;
  localparam int PEAK_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PCM_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_RATE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_START  = 3'd4;

  localparam logic [RATE_W-1:0] RATE_RESET = 19'd48000;
  localparam int                MS_SCALE   = 1000;
  localparam int                MS_SCALE_W = 10;

  // status of the shared multiply/divide unit
  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

`default_nettype wire

@@ hdl/ssd_muldiv.sv @@
// ----------------------------------------------------------------------------
// ssd_muldiv
// Bit-serial unit computing (a*b + c) / d: shift-add multiply one bit of b
// per cycle, an add step, then restoring division one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_muldiv import ssd_pkg::*; #(
  parameter int A_W = INDEX_BITS_DEF,
  parameter int B_W = RATE_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [A_W-1:0]       a,
  input  wire logic [B_W-1:0]       b,
  input  wire logic [B_W-1:0]       c,
  input  wire logic [B_W-1:0]       d,
  output md_stat_t                  stat,
  output logic      [A_W+B_W-1:0]   q
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(P_W);

  typedef enum logic [3:0] {
    MD_IDLE = 4'b0001,
    MD_MUL  = 4'b0010,
    MD_ADD  = 4'b0100,
    MD_DIV  = 4'b1000
  } md_phase_t;

  md_phase_t        phase_r, phase_nxt;
  logic             done_r, done_nxt;
  logic [P_W-1:0]   acc_r, acc_nxt;
  logic [A_W-1:0]   a_r, a_nxt;
  logic [B_W-1:0]   bsh_r, bsh_nxt;
  logic [B_W-1:0]   c_r, c_nxt;
  logic [B_W-1:0]   d_r, d_nxt;
  logic [B_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [B_W:0]     rem_sh;
  logic [B_W+1:0]   diff;
  logic             ge;

  always_comb begin
    rem_sh    = {rem_r, acc_r[P_W-1]};
    diff      = {1'b0, rem_sh} - {2'b00, d_r};
    ge        = ~diff[B_W+1];

    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    acc_nxt   = acc_r;
    a_nxt     = a_r;
    bsh_nxt   = bsh_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;

    case (phase_r)
      MD_IDLE: begin
        if (start) begin
          a_nxt     = a;
          bsh_nxt   = b;
          c_nxt     = c;
          d_nxt     = d;
          acc_nxt   = '0;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(B_W - 1);
          phase_nxt = MD_MUL;
        end
      end
      MD_MUL: begin
        // MSB-first shift-add
        acc_nxt = {acc_r[P_W-2:0], 1'b0} + (bsh_r[B_W-1] ? P_W'(a_r) : '0);
        bsh_nxt = {bsh_r[B_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          phase_nxt = MD_ADD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      MD_ADD: begin
        acc_nxt   = acc_r + P_W'(c_r);
        cnt_nxt   = CNT_W'(P_W - 1);
        phase_nxt = MD_DIV;
      end
      MD_DIV: begin
        // dividend shifts out of acc, quotient bits shift in
        acc_nxt = {acc_r[P_W-2:0], ge};
        rem_nxt = ge ? diff[B_W-1:0] : rem_sh[B_W-1:0];
        if (cnt_r == '0) begin
          phase_nxt = MD_IDLE;
          done_nxt  = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        phase_nxt = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    bsh_r <= bsh_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = (phase_r != MD_IDLE);
  assign stat.done = done_r;
  assign q         = acc_r;

endmodule

`default_nettype wire

@@ hdl/silence_run_detector.sv @@
// An item that closes no reportable run leaves in_tready high, so the next can follow.
// An item that closes a run holds off the next one through ST_LEN, ST_CMP, ST_CONV_A,
// ST_CONV_B and ST_DONE, while the bit-serial muldiv does two conversions.
// A run rejected as too short holds off input through ST_LEN and ST_CMP. One item at a
// time; a held result stalls input only once the next result is ready to load.
// Reset (rst_n low, synchronous): no run open, position 0, registers to their reset values.
// ----------------------------------------------------------------------------
// silence_run_detector
// Finds runs of quiet PCM samples and reports their source positions and peak.
// ----------------------------------------------------------------------------
`default_nettype none

module silence_run_detector import ssd_pkg::*; #(
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // sample [SAMPLE_BITS-1:0], zero padded to bytes
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  input  wire logic                                 in_tlast,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // run_start [40:0], run_end [81:41], run_peak [97:82], zero padded
  output logic [((2*OUT_W+PEAK_W+7)/8)*8-1:0]       out_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic                                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0]                 cfg_index,
  input  wire logic [CFG_DATA_W-1:0]                cfg_wdata
);

  localparam int OUT_TDATA_W = ((2*OUT_W+PEAK_W+7)/8)*8;
  localparam int PROD_W      = INDEX_BITS + RATE_W;
  localparam int MAG_CMP_W   = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int LEN_W       = INDEX_BITS + MS_SCALE_W;
  localparam int MIN_W       = MS_W + RATE_W;
  localparam int LCMP_W      = (LEN_W > MIN_W) ? LEN_W : MIN_W;
  localparam int SUM_W       = ((PROD_W > SRC_W) ? PROD_W : SRC_W) + 2;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LEN    = 6'b000010,
    ST_CMP    = 6'b000100,
    ST_CONV_A = 6'b001000,
    ST_CONV_B = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  // configuration
  logic [THR_W-1:0]  thr_r;
  logic [MS_W-1:0]   min_ms_r;
  logic [RATE_W-1:0] pcm_rate_r;
  logic [RATE_W-1:0] src_rate_r;
  logic [SRC_W-1:0]  src_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= '0;
      min_ms_r    <= '0;
      pcm_rate_r  <= RATE_RESET;
      src_rate_r  <= RATE_RESET;
      src_start_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_r       <= cfg_wdata[THR_W-1:0];
        CFG_MIN_MS:    min_ms_r    <= cfg_wdata[MS_W-1:0];
        CFG_PCM_RATE:  pcm_rate_r  <= cfg_wdata[RATE_W-1:0];
        CFG_SRC_RATE:  src_rate_r  <= cfg_wdata[RATE_W-1:0];
        CFG_SRC_START: src_start_r <= cfg_wdata[SRC_W-1:0];
        default: ;
      endcase
    end
  end

  logic [RATE_W-1:0] pcm_eff;
  assign pcm_eff = (pcm_rate_r == '0) ? RATE_W'(1) : pcm_rate_r;

  // state
  state_t                 state_r, state_nxt;
  logic                   run_open_r, run_open_nxt;
  logic [INDEX_BITS-1:0]  first_r, first_nxt;
  logic [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic [INDEX_BITS-1:0]  pos_r, pos_nxt;

  // work registers of the item being finished
  logic [INDEX_BITS-1:0]  w_first_r, w_first_nxt;
  logic [INDEX_BITS-1:0]  w_end_r, w_end_nxt;
  logic [SAMPLE_BITS-1:0] w_peak_r, w_peak_nxt;
  logic [LEN_W-1:0]       lenk_r, lenk_nxt;
  logic                   lenz_r, lenz_nxt;
  logic [MIN_W-1:0]       minp_r, minp_nxt;
  logic [OUT_W-1:0]       res_start_r, res_start_nxt;
  logic [OUT_W-1:0]       res_end_r, res_end_nxt;

  // output register
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]       out_start_r, out_start_nxt;
  logic [OUT_W-1:0]       out_end_r, out_end_nxt;
  logic [PEAK_W-1:0]      out_peak_r, out_peak_nxt;

  // shared unit
  logic                   md_start;
  md_stat_t               md_stat;
  logic [PROD_W-1:0]      md_q;
  logic [INDEX_BITS-1:0]  md_a;

  assign md_a = (state_r == ST_CMP) ? w_first_r : w_end_r;

  ssd_muldiv #(
    .A_W (INDEX_BITS),
    .B_W (RATE_W)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a     (md_a),
    .b     (src_rate_r),
    .c     (pcm_eff >> 1),
    .d     (pcm_eff),
    .stat  (md_stat),
    .q     (md_q)
  );

  // per-item decode
  logic                   in_fire;
  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] mag;
  logic                   silent;
  logic [INDEX_BITS-1:0]  pos_inc;
  logic [INDEX_BITS-1:0]  first_a;
  logic [SAMPLE_BITS-1:0] max_a;
  logic                   close_en;
  logic [INDEX_BITS-1:0]  close_first;
  logic [INDEX_BITS-1:0]  close_end;
  logic [SAMPLE_BITS-1:0] close_peak;
  logic [INDEX_BITS-1:0]  run_len;
  logic                   len_ok;
  logic [SUM_W-1:0]       conv_sum;
  logic [OUT_W-1:0]       conv_sat;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    raw     = in_tdata[SAMPLE_BITS-1:0];
    mag     = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    silent  = MAG_CMP_W'(mag) <= MAG_CMP_W'(thr_r);
    pos_inc = (pos_r == '1) ? pos_r : pos_r + 1'b1;
    first_a = run_open_r ? first_r : pos_r;
    if (!run_open_r) begin
      max_a = mag;
    end else begin
      max_a = (mag > max_r) ? mag : max_r;
    end

    if (!silent) begin
      close_en    = run_open_r;
      close_first = first_r;
      close_end   = pos_r;
      close_peak  = max_r;
    end else begin
      // silent sample with last joins the run, which ends just after it
      close_en    = in_tlast;
      close_first = first_a;
      close_end   = pos_inc;
      close_peak  = max_a;
    end

    run_len  = w_end_r - w_first_r;
    len_ok   = !lenz_r && (LCMP_W'(lenk_r) >= LCMP_W'(minp_r));
    conv_sum = SUM_W'(src_start_r) + SUM_W'(md_q);
    conv_sat = (|conv_sum[SUM_W-1:OUT_W]) ? '1 : conv_sum[OUT_W-1:0];
  end

  always_comb begin
    state_nxt      = state_r;
    run_open_nxt   = run_open_r;
    first_nxt      = first_r;
    max_nxt        = max_r;
    pos_nxt        = pos_r;
    w_first_nxt    = w_first_r;
    w_end_nxt      = w_end_r;
    w_peak_nxt     = w_peak_r;
    lenk_nxt       = lenk_r;
    lenz_nxt       = lenz_r;
    minp_nxt       = minp_r;
    res_start_nxt  = res_start_r;
    res_end_nxt    = res_end_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_start_nxt  = out_start_r;
    out_end_nxt    = out_end_r;
    out_peak_nxt   = out_peak_r;
    md_start       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          run_open_nxt = silent && !in_tlast;
          first_nxt    = (silent && !in_tlast) ? first_a : '0;
          max_nxt      = (silent && !in_tlast) ? max_a : '0;
          pos_nxt      = in_tlast ? '0 : pos_inc;
          w_first_nxt  = close_first;
          w_end_nxt    = close_end;
          w_peak_nxt   = close_peak;
          if (close_en) begin
            state_nxt = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        // len >= ceil(ms*rate/1000) <=> len*1000 >= ms*rate
        lenk_nxt  = LEN_W'(run_len) * LEN_W'(MS_SCALE);
        lenz_nxt  = (run_len == '0);
        minp_nxt  = MIN_W'(min_ms_r) * MIN_W'(pcm_eff);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (len_ok) begin
          md_start  = 1'b1;
          state_nxt = ST_CONV_A;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CONV_A: begin
        if (md_stat.done) begin
          res_start_nxt = conv_sat;
          md_start      = 1'b1;
          state_nxt     = ST_CONV_B;
        end
      end
      ST_CONV_B: begin
        if (md_stat.done) begin
          res_end_nxt = conv_sat;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_start_nxt  = res_start_r;
          out_end_nxt    = res_end_r;
          out_peak_nxt   = PEAK_W'(w_peak_r);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      run_open_r   <= 1'b0;
      first_r      <= '0;
      max_r        <= '0;
      pos_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      run_open_r   <= run_open_nxt;
      first_r      <= first_nxt;
      max_r        <= max_nxt;
      pos_r        <= pos_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_first_r   <= w_first_nxt;
    w_end_r     <= w_end_nxt;
    w_peak_r    <= w_peak_nxt;
    lenk_r      <= lenk_nxt;
    lenz_r      <= lenz_nxt;
    minp_r      <= minp_nxt;
    res_start_r <= res_start_nxt;
    res_end_r   <= res_end_nxt;
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
    out_peak_r  <= out_peak_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({out_peak_r, out_end_r, out_start_r});

  // checks
  a_no_close_idle : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !close_en |=> state_r == ST_IDLE)
    else $error("item without a closing run left the idle state");

  a_last_clears : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> !run_open_r && pos_r == '0)
    else $error("run or position survived a last item");

  a_md_free : assert property (@(posedge clk) disable iff (!rst_n)
    md_start |-> !md_stat.busy)
    else $error("muldiv started while busy");

  a_md_working : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV_A || state_r == ST_CONV_B) && !md_stat.done |-> md_stat.busy)
    else $error("conversion waiting on an idle muldiv");

endmodule

`default_nettype wire
